// ----- design/i2c_master_bit_sequencer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the I2C master bit sequencer
// Same-cycle and next-cycle implication forms on the block clock.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define I2CMBS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2c sequencer check failed");

// next-cycle implication, disabled in reset
`define I2CMBS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2c sequencer check failed");

`endif

// ----- design/i2cmbs_pkg.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer package
// Phase and command codes, bit timing constants and the sequencer state.
// ---------------------------------------------------------------------------
package i2cmbs_pkg;

   localparam int START_HOLD    = 4;
   localparam int STOP_HOLD     = 4;
   localparam int BYTE_HOLD     = 2;
   localparam int ACK_HOLD      = 1;
   localparam int BITS_PER_BYTE = 8;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_WAIT  = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B,
      PH_WR_D, PH_WR_H, PH_WR_L,
      PH_RD_D, PH_RD_H, PH_RD_L,
      PH_ACK_A, PH_ACK_B,
      PH_WA_A, PH_WA_B, PH_WA_P
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_count;
      logic [7:0] shift_reg;
      logic [2:0] hold_count;
      logic [7:0] wait_count;
      logic       scl;
      logic       sda_pull;
      logic       ack_flag;
      logic       nack_choice;
      logic [7:0] rx_last;
   } seq_state_type;

endpackage

// ----- design/i2cmbs_channels.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer channels
// Valid/ready channels for tick items and for the line levels they produce.
// ---------------------------------------------------------------------------
interface i2cmbs_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] tx_byte;
   logic       send_nack;
   logic       sda_in;

   modport source (output valid, operation, tx_byte, send_nack, sda_in, input ready);
   modport sink (input valid, operation, tx_byte, send_nack, sda_in, output ready);
endinterface

interface i2cmbs_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_pull_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_ok;

   modport source (output valid, scl_level, sda_pull_low, busy_res, done_res, rx_byte,
                   ack_ok, input ready);
   modport sink (input valid, scl_level, sda_pull_low, busy_res, done_res, rx_byte,
                 ack_ok, output ready);
endinterface

// ----- design/i2c_master_bit_sequencer_core.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain SCL/SDA sequencer advanced by one tick item per accepted item.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one time-base tick per item: the sampled SDA level and an
//   optional command (start, stop, write byte, read byte, wait ack). A
//   command is taken only while the sequencer is idle; otherwise ignored.
//   rsp_ch returns exactly one item per tick item: the SCL and SDA drive
//   levels, busy, a done pulse, the last read byte and the last ack result.
//   The result item is registered and valid in the cycle after acceptance;
//   one item is accepted per cycle while rsp_ch does not stall, the tick
//   step being a single pass of logic between the state registers and the
//   result register. The result register is the only buffer: req_ch.ready
//   stays high while it is empty or being drained, so a stalled rsp_ch
//   stalls req_ch after one item and nothing is lost.
//   csr_wr_en/csr_wr_data write the acknowledge timeout (ticks of SDA high
//   tolerated while polling); write it only while idle.
//   Synchronous reset returns to idle with SCL released, SDA released and
//   the timeout at 250; no result is pending after reset.
// ---------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2c_master_bit_sequencer_core (
   input  logic               clock,
   input  logic               reset,
   i2cmbs_req_if.sink         req_ch,
   i2cmbs_rsp_if.source       rsp_ch,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);
   import i2cmbs_pkg::*;

   seq_state_type state_ff, state_in;
   logic [7:0]    ack_timeout_ff;
   logic          rsp_valid_ff;
   logic          done_in;
   logic          accept;

   logic          scl_ff, sda_ff, busy_ff, done_ff, ack_ff;
   logic [7:0]    rx_ff;

   i2cmbs_step u_step (
      .cur         (state_ff),
      .operation   (req_ch.operation),
      .tx_byte     (req_ch.tx_byte),
      .send_nack   (req_ch.send_nack),
      .sda_in      (req_ch.sda_in),
      .ack_timeout (ack_timeout_ff),
      .nxt         (state_in),
      .done        (done_in)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '{phase: PH_IDLE, bit_count: 4'd0, shift_reg: 8'd0,
                             hold_count: 3'd0, wait_count: 8'd0, scl: 1'b1,
                             sda_pull: 1'b0, ack_flag: 1'b0, nack_choice: 1'b0,
                             rx_last: 8'd0};
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en)
            ack_timeout_ff <= csr_wr_data;
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with each accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         scl_ff  <= state_in.scl;
         sda_ff  <= state_in.sda_pull;
         busy_ff <= (state_in.phase != PH_IDLE);
         done_ff <= done_in;
         rx_ff   <= state_in.rx_last;
         ack_ff  <= state_in.ack_flag;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_level    = scl_ff;
   assign rsp_ch.sda_pull_low = sda_ff;
   assign rsp_ch.busy_res     = busy_ff;
   assign rsp_ch.done_res     = done_ff;
   assign rsp_ch.rx_byte      = rx_ff;
   assign rsp_ch.ack_ok       = ack_ff;

   `I2CMBS_ASSERT_SAME(a_done_not_busy, rsp_ch.valid && rsp_ch.done_res, !rsp_ch.busy_res)
   `I2CMBS_ASSERT_NEXT(a_accept_gives_result, accept, rsp_ch.valid)
   `I2CMBS_ASSERT_NEXT(a_idle_noop_stays_idle,
      accept && state_ff.phase == PH_IDLE && req_ch.operation == OP_NONE,
      !rsp_ch.busy_res && !rsp_ch.done_res)

endmodule

// ----- design/i2cmbs_step.sv -----
// ---------------------------------------------------------------------------
// I2C master bit sequencer tick step
// Next sequencer state and done flag for one tick, purely combinational.
// ---------------------------------------------------------------------------
module i2cmbs_step (
   input  i2cmbs_pkg::seq_state_type cur,
   input  logic [2:0]                operation,
   input  logic [7:0]                tx_byte,
   input  logic                      send_nack,
   input  logic                      sda_in,
   input  logic [7:0]                ack_timeout,
   output i2cmbs_pkg::seq_state_type nxt,
   output logic                      done
);
   import i2cmbs_pkg::*;

   // enter a level: phase, line levels and remaining hold ticks
   function automatic seq_state_type go(seq_state_type s, phase_type p, logic scl,
                                        logic pull, int hold);
      seq_state_type r;
      r            = s;
      r.phase      = p;
      r.scl        = scl;
      r.sda_pull   = pull;
      r.hold_count = 3'(hold - 1);
      return r;
   endfunction

   logic [3:0] bit_count_inc;
   logic [7:0] shift_left;

   assign bit_count_inc = cur.bit_count + 4'd1;
   assign shift_left    = {cur.shift_reg[6:0], 1'b0};

   always_comb begin
      nxt  = cur;
      done = 1'b0;
      if (cur.phase == PH_IDLE) begin
         case (op_type'(operation))
            OP_START: nxt = go(cur, PH_ST_A, 1'b1, 1'b0, START_HOLD);
            OP_STOP:  nxt = go(cur, PH_SP_A, 1'b0, 1'b1, STOP_HOLD);
            OP_WRITE: begin
               nxt           = go(cur, PH_WR_D, 1'b0, ~tx_byte[7], BYTE_HOLD);
               nxt.shift_reg = tx_byte;
               nxt.bit_count = 4'd0;
            end
            OP_READ: begin
               nxt             = go(cur, PH_RD_D, 1'b0, 1'b0, BYTE_HOLD);
               nxt.shift_reg   = 8'd0;
               nxt.bit_count   = 4'd0;
               nxt.nack_choice = send_nack;
            end
            OP_WAIT: begin
               nxt            = go(cur, PH_WA_A, cur.scl, 1'b0, ACK_HOLD);
               nxt.wait_count = 8'd0;
            end
            default: ;
         endcase
      end else if (cur.phase == PH_WA_P) begin
         if (!sda_in) begin
            nxt.scl      = 1'b0;
            nxt.ack_flag = 1'b1;
            nxt.phase    = PH_IDLE;
            done         = 1'b1;
         end else if (cur.wait_count >= ack_timeout) begin
            // timed out: report failure and release the bus with a stop
            nxt          = go(cur, PH_SP_A, 1'b0, 1'b1, STOP_HOLD);
            nxt.ack_flag = 1'b0;
         end else begin
            nxt.wait_count = cur.wait_count + 8'd1;
         end
      end else if (cur.hold_count != 3'd0) begin
         // sample a read bit while SCL is high, when one hold tick remains
         if (cur.phase == PH_RD_H && cur.hold_count == 3'd1)
            nxt.shift_reg = {cur.shift_reg[6:0], sda_in};
         nxt.hold_count = cur.hold_count - 3'd1;
      end else begin
         unique case (cur.phase)
            PH_ST_A: nxt = go(cur, PH_ST_B, 1'b1, 1'b1, START_HOLD);
            PH_ST_B: begin
               nxt.scl   = 1'b0;
               nxt.phase = PH_IDLE;
               done      = 1'b1;
            end
            PH_SP_A: nxt = go(cur, PH_SP_B, 1'b1, 1'b0, STOP_HOLD);
            PH_SP_B: begin
               nxt.phase = PH_IDLE;
               done      = 1'b1;
            end
            PH_WR_D: nxt = go(cur, PH_WR_H, 1'b1, cur.sda_pull, BYTE_HOLD);
            PH_WR_H: nxt = go(cur, PH_WR_L, 1'b0, cur.sda_pull, BYTE_HOLD);
            PH_WR_L: begin
               if (bit_count_inc >= 4'(BITS_PER_BYTE)) begin
                  nxt.phase = PH_IDLE;
                  done      = 1'b1;
               end else begin
                  nxt = go(cur, PH_WR_D, 1'b0, ~shift_left[7], BYTE_HOLD);
               end
               nxt.bit_count = bit_count_inc;
               nxt.shift_reg = shift_left;
            end
            PH_RD_D: nxt = go(cur, PH_RD_H, 1'b1, 1'b0, BYTE_HOLD);
            PH_RD_H: nxt = go(cur, PH_RD_L, 1'b0, 1'b0, BYTE_HOLD);
            PH_RD_L: begin
               if (bit_count_inc >= 4'(BITS_PER_BYTE))
                  nxt = go(cur, PH_ACK_A, 1'b0, ~cur.nack_choice, ACK_HOLD);
               else
                  nxt = go(cur, PH_RD_D, 1'b0, 1'b0, BYTE_HOLD);
               nxt.bit_count = bit_count_inc;
            end
            PH_ACK_A: nxt = go(cur, PH_ACK_B, 1'b1, cur.sda_pull, ACK_HOLD);
            PH_ACK_B: begin
               nxt.scl      = 1'b0;
               nxt.sda_pull = 1'b0;
               nxt.rx_last  = cur.shift_reg;
               nxt.phase    = PH_IDLE;
               done         = 1'b1;
            end
            PH_WA_A: nxt = go(cur, PH_WA_B, 1'b1, 1'b0, ACK_HOLD);
            PH_WA_B: nxt = go(cur, PH_WA_P, 1'b1, 1'b0, ACK_HOLD);
            default: nxt.phase = PH_IDLE;
         endcase
      end
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Feeds tick items carrying commands and SDA samples into the sequencer and
// compares every returned result (line levels, busy, done, read byte, ack)
// against a tick-exact model of the start, stop, write, read and wait-ack
// sequences, under several ack timeouts and sender/receiver idling patterns.
// ---------------------------------------------------------------------------
module testbench;
   import i2cmbs_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD_OFF = 300;
   localparam int REPORT_CAP = 40;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] tx;
      logic       nack;
      logic       sda;
   } tick_item_type;

   typedef struct packed {
      logic       scl;
      logic       sda_pull;
      logic       busy;
      logic       done;
      logic [7:0] rx;
      logic       ack;
   } bus_levels_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   i2cmbs_req_if req_ch();
   i2cmbs_rsp_if rsp_ch();

   i2c_master_bit_sequencer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tick_item_type  tick_queue[$];
   bus_levels_type expected_levels[$];

   // sequencer model state
   phase_type  seq_phase;
   logic [3:0] seq_bits;
   logic [7:0] seq_shift;
   logic [2:0] seq_hold;
   logic [7:0] seq_wait;
   logic       seq_scl;
   logic       seq_sda;
   logic       seq_ack;
   logic       seq_nack;
   logic [7:0] seq_rx;
   logic [7:0] model_timeout;

   int send_idle_pct;
   int recv_stall_pct;
   int stall_requests;
   int stall_served;
   int hold_left;
   int quiet_cycles;
   int mismatches;
   int ticks_accepted;
   int results_checked;
   int commands_done;
   int reads_done;
   int ack_timeouts;
   int timeout_settings;

   function void move_to(input phase_type p, input logic scl, input logic pull, input int hold);
      seq_phase = p;
      seq_scl = scl;
      seq_sda = pull;
      seq_hold = 3'(hold - 1);
   endfunction

   function bus_levels_type step_bit_sequencer(input logic [2:0] op, input logic [7:0] tx,
                                               input logic nk, input logic sdi);
      bus_levels_type r;
      logic done;
      done = 1'b0;
      if (seq_phase == PH_IDLE) begin
         case (op)
            OP_START: move_to(PH_ST_A, 1'b1, 1'b0, START_HOLD);
            OP_STOP:  move_to(PH_SP_A, 1'b0, 1'b1, STOP_HOLD);
            OP_WRITE: begin
               seq_shift = tx;
               seq_bits = 4'd0;
               move_to(PH_WR_D, 1'b0, ~tx[7], BYTE_HOLD);
            end
            OP_READ: begin
               seq_shift = 8'd0;
               seq_bits = 4'd0;
               seq_nack = nk;
               move_to(PH_RD_D, 1'b0, 1'b0, BYTE_HOLD);
            end
            OP_WAIT: begin
               seq_wait = 8'd0;
               move_to(PH_WA_A, seq_scl, 1'b0, ACK_HOLD);
            end
            default: ;
         endcase
      end else if (seq_phase == PH_WA_P) begin
         if (!sdi) begin
            seq_scl = 1'b0;
            seq_ack = 1'b1;
            seq_phase = PH_IDLE;
            done = 1'b1;
         end else if (seq_wait >= model_timeout) begin
            // give up: release the bus through a stop
            seq_ack = 1'b0;
            ack_timeouts++;
            move_to(PH_SP_A, 1'b0, 1'b1, STOP_HOLD);
         end else begin
            seq_wait = seq_wait + 8'd1;
         end
      end else if (seq_hold != 3'd0) begin
         // sample while SCL is high, when one hold tick remains
         if (seq_phase == PH_RD_H && seq_hold == 3'd1)
            seq_shift = {seq_shift[6:0], sdi};
         seq_hold = seq_hold - 3'd1;
      end else begin
         case (seq_phase)
            PH_ST_A: move_to(PH_ST_B, 1'b1, 1'b1, START_HOLD);
            PH_ST_B: begin
               seq_scl = 1'b0;
               seq_phase = PH_IDLE;
               done = 1'b1;
            end
            PH_SP_A: move_to(PH_SP_B, 1'b1, 1'b0, STOP_HOLD);
            PH_SP_B: begin
               seq_phase = PH_IDLE;
               done = 1'b1;
            end
            PH_WR_D: move_to(PH_WR_H, 1'b1, seq_sda, BYTE_HOLD);
            PH_WR_H: move_to(PH_WR_L, 1'b0, seq_sda, BYTE_HOLD);
            PH_WR_L: begin
               seq_bits = seq_bits + 4'd1;
               seq_shift = {seq_shift[6:0], 1'b0};
               if (seq_bits >= BITS_PER_BYTE) begin
                  seq_phase = PH_IDLE;
                  done = 1'b1;
               end else begin
                  move_to(PH_WR_D, 1'b0, ~seq_shift[7], BYTE_HOLD);
               end
            end
            PH_RD_D: move_to(PH_RD_H, 1'b1, 1'b0, BYTE_HOLD);
            PH_RD_H: move_to(PH_RD_L, 1'b0, 1'b0, BYTE_HOLD);
            PH_RD_L: begin
               seq_bits = seq_bits + 4'd1;
               if (seq_bits >= BITS_PER_BYTE)
                  move_to(PH_ACK_A, 1'b0, ~seq_nack, ACK_HOLD);
               else
                  move_to(PH_RD_D, 1'b0, 1'b0, BYTE_HOLD);
            end
            PH_ACK_A: move_to(PH_ACK_B, 1'b1, seq_sda, ACK_HOLD);
            PH_ACK_B: begin
               seq_scl = 1'b0;
               seq_sda = 1'b0;
               seq_rx = seq_shift;
               seq_phase = PH_IDLE;
               done = 1'b1;
               reads_done++;
            end
            PH_WA_A: move_to(PH_WA_B, 1'b1, 1'b0, ACK_HOLD);
            PH_WA_B: move_to(PH_WA_P, 1'b1, 1'b0, ACK_HOLD);
            default: seq_phase = PH_IDLE;
         endcase
      end
      if (done)
         commands_done++;
      r.scl = seq_scl;
      r.sda_pull = seq_sda;
      r.busy = (seq_phase != PH_IDLE);
      r.done = done;
      r.rx = seq_rx;
      r.ack = seq_ack;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   function logic line_level(input int sda_mode);
      if (sda_mode < 0)
         return 1'($urandom_range(1));
      return sda_mode[0];
   endfunction

   task automatic push_tick(input logic [2:0] op, input logic [7:0] tx, input logic nk,
                            input logic sda);
      tick_item_type t;
      t.op = op;
      t.tx = tx;
      t.nack = nk;
      t.sda = sda;
      tick_queue.push_back(t);
   endtask

   // Queue one command and the ticks that carry it to completion. Wait-ack
   // polls see `highs` high samples before a low one, or time out.
   task automatic run_command(input logic [2:0] op, input logic [7:0] tx, input logic nk,
                              input int highs, input int sda_mode);
      int span;
      int extra;
      int t;
      logic s;
      logic [2:0] o;
      case (op)
         OP_START, OP_STOP: span = 8;
         OP_WRITE: span = 48;
         OP_READ: span = 50;
         default: span = (highs <= model_timeout) ? 3 + highs : 11 + model_timeout;
      endcase
      extra = $urandom_range(2);
      push_tick(op, tx, nk, line_level(sda_mode));
      for (t = 1; t <= span + extra; t++) begin
         s = line_level(sda_mode);
         if (op == OP_WAIT && t >= 3) begin
            if (highs <= model_timeout) begin
               if (t - 3 < highs)
                  s = 1'b1;
               else if (t - 3 == highs)
                  s = 1'b0;
            end else if (t - 3 <= model_timeout) begin
               s = 1'b1;
            end
         end
         // commands while busy and unused codes while idle are both ignored
         if (t <= span)
            o = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : OP_NONE;
         else
            o = ($urandom_range(5) == 0) ? 3'($urandom_range(7, 6)) : OP_NONE;
         push_tick(o, 8'($urandom), 1'($urandom), s);
      end
   endtask

   task automatic random_command();
      int pick;
      int highs;
      int r;
      int sda_mode;
      logic [2:0] op;
      pick = $urandom_range(99);
      if (pick < 15)
         op = OP_START;
      else if (pick < 30)
         op = OP_STOP;
      else if (pick < 55)
         op = OP_WRITE;
      else if (pick < 80)
         op = OP_READ;
      else
         op = OP_WAIT;
      if (model_timeout <= 24)
         highs = $urandom_range(model_timeout + 1);
      else
         highs = $urandom_range(6);
      r = $urandom_range(7);
      sda_mode = (r < 2) ? r : -1;
      run_command(op, 8'($urandom), 1'($urandom), highs, sda_mode);
   endtask

   // Hold the sender until every result is in and the sequencer is idle.
   task automatic finish_phase();
      forever begin
         while (tick_queue.size() != 0 || req_ch.valid || expected_levels.size() != 0)
            @(posedge clock);
         if (seq_phase == PH_IDLE)
            break;
         repeat (64) push_tick(OP_NONE, 8'h00, 1'b0, 1'b0);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [7:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      model_timeout = value;
      timeout_settings++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // tick item driver
   always @(posedge clock) begin : drive_ticks
      tick_item_type nxt_tick;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.operation <= OP_NONE;
         req_ch.tx_byte <= 8'h00;
         req_ch.send_nack <= 1'b0;
         req_ch.sda_in <= 1'b0;
         seq_phase = PH_IDLE;
         seq_bits = 4'd0;
         seq_shift = 8'd0;
         seq_hold = 3'd0;
         seq_wait = 8'd0;
         seq_scl = 1'b1;
         seq_sda = 1'b0;
         seq_ack = 1'b0;
         seq_nack = 1'b0;
         seq_rx = 8'd0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_levels.push_back(step_bit_sequencer(req_ch.operation, req_ch.tx_byte,
                                                         req_ch.send_nack, req_ch.sda_in));
            ticks_accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt_tick = tick_queue.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.operation <= nxt_tick.op;
               req_ch.tx_byte <= nxt_tick.tx;
               req_ch.send_nack <= nxt_tick.nack;
               req_ch.sda_in <= nxt_tick.sda;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_served != stall_requests) begin
            stall_served++;
            hold_left = LONG_HOLD_OFF;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_levels
      bus_levels_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_levels.size() == 0) begin
            mismatches++;
            $display("%0t: result item with nothing expected", $time);
         end else begin
            want = expected_levels.pop_front();
            results_checked++;
            check_field("scl_level", 8'(want.scl), 8'(rsp_ch.scl_level));
            check_field("sda_pull_low", 8'(want.sda_pull), 8'(rsp_ch.sda_pull_low));
            check_field("busy_res", 8'(want.busy), 8'(rsp_ch.busy_res));
            check_field("done_res", 8'(want.done), 8'(rsp_ch.done_res));
            check_field("rx_byte", want.rx, rsp_ch.rx_byte);
            check_field("ack_ok", 8'(want.ack), 8'(rsp_ch.ack_ok));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, expected_levels.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [7:0] settings[6];
      int p;
      int i;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'h00;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      stall_requests = 0;
      timeout_settings = 1;
      model_timeout = ACK_TIMEOUT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: every command and its edge values at the reset timeout
      run_command(OP_WAIT, 8'h00, 1'b0, 0, -1);
      run_command(OP_START, 8'h00, 1'b0, 0, -1);
      run_command(OP_WRITE, 8'hFF, 1'b0, 0, -1);
      run_command(OP_WRITE, 8'h00, 1'b1, 0, -1);
      run_command(OP_WAIT, 8'h00, 1'b0, 3, -1);
      run_command(OP_READ, 8'h00, 1'b0, 0, 1);
      run_command(OP_READ, 8'hFF, 1'b1, 0, 0);
      push_tick(3'd6, 8'hFF, 1'b1, 1'b1);
      push_tick(3'd7, 8'h00, 1'b0, 1'b0);
      push_tick(OP_WRITE, 8'hA5, 1'b0, 1'b1);
      push_tick(OP_START, 8'h00, 1'b0, 1'b0);
      repeat (47) push_tick(OP_NONE, 8'h00, 1'b0, 1'b1);
      run_command(OP_STOP, 8'h00, 1'b0, 0, -1);
      finish_phase();

      // zero timeout: first high poll fails, an immediate low still acks
      write_timeout(8'd0);
      run_command(OP_WAIT, 8'h00, 1'b0, 1, -1);
      run_command(OP_WAIT, 8'h00, 1'b0, 0, -1);
      finish_phase();

      settings[0] = 8'd255;
      settings[1] = 8'd3;
      settings[2] = 8'd0;
      settings[3] = 8'($urandom_range(20, 1));
      settings[4] = 8'd1;
      settings[5] = ACK_TIMEOUT_RESET;
      for (p = 0; p < 6; p++) begin
         write_timeout(settings[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         // longest possible wait-ack, run to the timeout
         if (p == 0)
            run_command(OP_WAIT, 8'h00, 1'b0, 256, -1);
         for (i = 0; i < 4; i++)
            random_command();
         if (p == 0)
            stall_requests++;
         finish_phase();
      end

      repeat (8) @(posedge clock);
      $display("Ran %0d tick items, %0d results checked, over %0d timeout settings",
               ticks_accepted, results_checked, timeout_settings);
      $display("with four idling patterns; %0d commands done, %0d reads, %0d ack timeouts",
               commands_done, reads_done, ack_timeouts);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/i2cmbs_pkg.sv
design/i2cmbs_channels.sv
design/i2cmbs_step.sv
design/i2c_master_bit_sequencer_core.sv
sim/testbench.sv
